[hw/rtl/assert_macros.svh]
// Assertion macros used by the top-level decompressor RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LBT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
`define LBT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define LBT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LBT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/lbt_pkg.sv]
// Types, codes and tree tables of the bit-tree decompressor
package lbt_pkg;

    typedef enum logic [3:0] {
        PH_WORD_LO,
        PH_WORD_HI,
        PH_FLAG,
        PH_COUNT,
        PH_OFFSET,
        PH_LITERAL,
        PH_ESCAPE,
        PH_LOWOFF,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LIT,
        BK_RD,
        BK_DATA,
        BK_FLUSH,
        BK_END
    } back_state_t;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_COPY,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  byte_val;
        logic [8:0]  run_len;
        logic [12:0] offset;
    } cmd_t;

    localparam logic [7:0] ESC_SKIP = 8'hFE;
    localparam logic [7:0] ESC_END  = 8'hFF;
    localparam logic [6:0] ESC_LEAF = 7'd25;
    localparam logic [8:0] ESC_BASE = 9'd25;
    localparam logic [6:0] SHORT_RUN = 7'd2;
    localparam logic [4:0] WORD_BITS = 5'd16;

    // entry {node, bit}; bit 7 marks a leaf
    localparam logic [7:0] COUNT_TREE [64] = '{
        8'h02, 8'h01, 8'h82, 8'h83, 8'h03, 8'h05, 8'h84, 8'h04,
        8'h85, 8'h86, 8'h06, 8'h08, 8'h87, 8'h07, 8'h88, 8'h89,
        8'h09, 8'h0B, 8'h8A, 8'h0A, 8'h8B, 8'h8C, 8'h0C, 8'h0E,
        8'h99, 8'h0D, 8'h8D, 8'h8E, 8'h0F, 8'h11, 8'h8F, 8'h10,
        8'h90, 8'h91, 8'h12, 8'h14, 8'h92, 8'h13, 8'h93, 8'h94,
        8'h15, 8'h16, 8'h95, 8'h96, 8'h97, 8'h98, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] OFFSET_TREE [64] = '{
        8'h01, 8'h80, 8'h02, 8'h07, 8'h03, 8'h04, 8'h81, 8'h82,
        8'h05, 8'h06, 8'h83, 8'h84, 8'h85, 8'h86, 8'h08, 8'h10,
        8'h09, 8'h0C, 8'h0A, 8'h0B, 8'h87, 8'h88, 8'h89, 8'h8A,
        8'h0D, 8'h0E, 8'h8B, 8'h8C, 8'h8D, 8'h0F, 8'h8E, 8'h8F,
        8'h11, 8'h18, 8'h12, 8'h15, 8'h13, 8'h14, 8'h90, 8'h91,
        8'h92, 8'h93, 8'h16, 8'h17, 8'h94, 8'h95, 8'h96, 8'h97,
        8'h19, 8'h1C, 8'h1A, 8'h1B, 8'h98, 8'h99, 8'h9A, 8'h9B,
        8'h1D, 8'h1E, 8'h9C, 8'h9D, 8'h9E, 8'h9F, 8'h00, 8'h00
    };

endpackage

[hw/rtl/lbt_channels.sv]
// Handshake channel interfaces of the decompressor
interface lbt_cfg_if;
    logic valid;
    logic ready;
    logic decrypt_enable;
    modport source (output valid, output decrypt_enable, input ready);
    modport sink (input valid, input decrypt_enable, output ready);
endinterface

interface lbt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface lbt_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last;
    logic        finished;
    modport source (output valid, output out_bytes, output byte_count, output last,
                    output finished, input ready);
    modport sink (input valid, input out_bytes, input byte_count, input last,
                  input finished, output ready);
endinterface

[hw/rtl/lz_bit_tree_decompressor.sv]
// A literal word passes the command queue and the IDLE, LIT and FLUSH states to the output.
// One compressed byte a cycle in byte phases, but literal, escape and low-offset bytes wait
// while the command queue is full. Copies run through the single-port history, read (RD)
// then write (DATA), for each output byte. Reset clears all control state at once; history
// needs no clearing pass, since a fill mark makes any entry not yet written read as zero.
`include "assert_macros.svh"

module lz_bit_tree_decompressor #(
    parameter int WINDOW_DEPTH = 8192,
    parameter int OUT_LANES    = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    lbt_cfg_if.sink   cfg,
    lbt_byte_if.sink  din,
    lbt_out_if.source dout
);

    logic          decrypt_reg;
    logic          push, pop, fifo_full, fifo_empty;
    lbt_pkg::cmd_t push_cmd, head;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decrypt_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            decrypt_reg <= cfg.decrypt_enable;
        end
    end

    lbt_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .decrypt_enable (decrypt_reg),
        .din            (din),
        .fifo_full      (fifo_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    lbt_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .empty    (fifo_empty),
        .head     (head)
    );

    lbt_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .OUT_LANES    (OUT_LANES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .head       (head),
        .pop        (pop),
        .dout       (dout)
    );

    `LBT_ASSERT_IMP(a_end_shape, clk, rst_n, dout.valid && dout.finished, dout.last && (dout.byte_count == 4'd0))
    `LBT_ASSERT_IMP(a_full_mid, clk, rst_n, dout.valid && !dout.last, dout.byte_count == 4'(OUT_LANES))
    `LBT_ASSERT_IMP(a_data_nonempty, clk, rst_n, dout.valid && !dout.finished, dout.byte_count != 4'd0)
    `LBT_ASSERT_NXT(a_silent_after_end, clk, rst_n, dout.valid && dout.ready && dout.finished, !dout.valid)

endmodule

[hw/rtl/lbt_cmd_fifo.sv]
// Two-entry command queue between front and back
module lbt_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lbt_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output lbt_pkg::cmd_t head
);

    lbt_pkg::cmd_t slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

[hw/rtl/lbt_front.sv]
// Front end: flag bits, trees and byte classification into commands
module lbt_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          decrypt_enable,
    lbt_byte_if.sink      din,
    input  logic          fifo_full,
    output logic          push,
    output lbt_pkg::cmd_t push_cmd
);

    lbt_pkg::phase_t phase_reg, phase_next;
    lbt_pkg::phase_t resume_reg, resume_next;
    logic [15:0] flag_reg, flag_next;
    logic [3:0]  bits_reg, bits_next;
    logic [4:0]  node_reg, node_next;
    logic [8:0]  len_reg, len_next;
    logic [4:0]  offhi_reg, offhi_next;

    logic accept;
    assign accept = din.valid && din.ready;

    always_comb
    begin
        logic            bitv;
        logic [3:0]      bits_inc;
        logic [7:0]      child;
        logic [7:0]      key;
        lbt_pkg::phase_t p;

        bitv     = flag_reg[bits_reg];
        bits_inc = bits_reg + 4'd1;
        child    = 8'h00;
        key      = 8'h00;
        p        = phase_reg;

        phase_next  = phase_reg;
        resume_next = resume_reg;
        flag_next   = flag_reg;
        bits_next   = bits_reg;
        node_next   = node_reg;
        len_next    = len_reg;
        offhi_next  = offhi_reg;
        din.ready   = 1'b0;
        push        = 1'b0;
        push_cmd    = '0;

        case (phase_reg)
            lbt_pkg::PH_WORD_LO:
            begin
                din.ready = 1'b1;
                if (accept)
                begin
                    flag_next  = {8'h00, din.in_byte};
                    phase_next = lbt_pkg::PH_WORD_HI;
                end
            end
            lbt_pkg::PH_WORD_HI:
            begin
                din.ready = 1'b1;
                if (accept)
                begin
                    flag_next  = {din.in_byte, flag_reg[7:0]};
                    phase_next = resume_reg;
                end
            end
            lbt_pkg::PH_LITERAL:
            begin
                din.ready = !fifo_full;
                if (accept)
                begin
                    key = decrypt_enable ? {3'b000, lbt_pkg::WORD_BITS - {1'b0, bits_reg}}
                                         : 8'h00;
                    push              = 1'b1;
                    push_cmd.kind     = lbt_pkg::CMD_LIT;
                    push_cmd.byte_val = din.in_byte ^ key;
                    phase_next        = lbt_pkg::PH_FLAG;
                end
            end
            lbt_pkg::PH_ESCAPE:
            begin
                din.ready = !fifo_full;
                if (accept)
                begin
                    if (din.in_byte == lbt_pkg::ESC_SKIP)
                    begin
                        phase_next = lbt_pkg::PH_FLAG;
                    end
                    else if (din.in_byte == lbt_pkg::ESC_END)
                    begin
                        push          = 1'b1;
                        push_cmd.kind = lbt_pkg::CMD_END;
                        phase_next    = lbt_pkg::PH_DONE;
                    end
                    else
                    begin
                        len_next   = {1'b0, din.in_byte} + lbt_pkg::ESC_BASE;
                        node_next  = 5'd0;
                        phase_next = lbt_pkg::PH_OFFSET;
                    end
                end
            end
            lbt_pkg::PH_LOWOFF:
            begin
                din.ready = !fifo_full;
                if (accept)
                begin
                    push             = 1'b1;
                    push_cmd.kind    = lbt_pkg::CMD_COPY;
                    push_cmd.run_len = len_reg;
                    push_cmd.offset  = {offhi_reg, din.in_byte};
                    phase_next       = lbt_pkg::PH_FLAG;
                end
            end
            lbt_pkg::PH_DONE:
            begin
                din.ready = 1'b1;
            end
            lbt_pkg::PH_FLAG, lbt_pkg::PH_COUNT, lbt_pkg::PH_OFFSET:
            begin
                if (phase_reg == lbt_pkg::PH_FLAG)
                begin
                    if (bitv)
                    begin
                        p         = lbt_pkg::PH_COUNT;
                        node_next = 5'd0;
                    end
                    else
                    begin
                        p = lbt_pkg::PH_LITERAL;
                    end
                end
                else if (phase_reg == lbt_pkg::PH_COUNT)
                begin
                    child = lbt_pkg::COUNT_TREE[{node_reg, bitv}];
                    if (child[7])
                    begin
                        if (child[6:0] == lbt_pkg::ESC_LEAF)
                        begin
                            p = lbt_pkg::PH_ESCAPE;
                        end
                        else
                        begin
                            len_next = {2'b00, child[6:0]};
                            if (child[6:0] == lbt_pkg::SHORT_RUN)
                            begin
                                offhi_next = 5'd0;
                                p          = lbt_pkg::PH_LOWOFF;
                            end
                            else
                            begin
                                node_next = 5'd0;
                                p         = lbt_pkg::PH_OFFSET;
                            end
                        end
                    end
                    else
                    begin
                        node_next = child[4:0];
                    end
                end
                else
                begin
                    child = lbt_pkg::OFFSET_TREE[{node_reg, bitv}];
                    if (child[7])
                    begin
                        offhi_next = child[4:0];
                        p          = lbt_pkg::PH_LOWOFF;
                    end
                    else
                    begin
                        node_next = child[4:0];
                    end
                end
                bits_next = bits_inc;
                if (bits_inc == 4'd0)
                begin
                    resume_next = p;
                    phase_next  = lbt_pkg::PH_WORD_LO;
                end
                else
                begin
                    phase_next = p;
                end
            end
            default:
            begin
                phase_next = lbt_pkg::PH_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= lbt_pkg::PH_WORD_LO;
            resume_reg <= lbt_pkg::PH_FLAG;
            flag_reg   <= 16'h0000;
            bits_reg   <= 4'd0;
            node_reg   <= 5'd0;
            len_reg    <= 9'd0;
            offhi_reg  <= 5'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            resume_reg <= resume_next;
            flag_reg   <= flag_next;
            bits_reg   <= bits_next;
            node_reg   <= node_next;
            len_reg    <= len_next;
            offhi_reg  <= offhi_next;
        end
    end

endmodule

[hw/rtl/lbt_back.sv]
// Back end: history window, copy engine and output packing
module lbt_back #(
    parameter int WINDOW_DEPTH = 8192,
    parameter int OUT_LANES    = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fifo_empty,
    input  lbt_pkg::cmd_t head,
    output logic          pop,
    lbt_out_if.source     dout
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(OUT_LANES + 1);
    localparam int DW = 8 * OUT_LANES;

    lbt_pkg::back_state_t st_reg, st_next;
    logic [7:0]    lit_reg, lit_next;
    logic [8:0]    remain_reg, remain_next;
    logic [12:0]   off_reg, off_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic          wrapped_reg, wrapped_next;
    logic [DW-1:0] acc_reg, acc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          zero_reg, zero_next;
    logic [7:0]    rdata_reg;
    logic [7:0]    mem [WINDOW_DEPTH];

    logic          out_valid_reg, out_valid_next;
    logic [63:0]   out_bytes_reg, out_bytes_next;
    logic [3:0]    out_cnt_reg, out_cnt_next;
    logic          out_last_reg, out_last_next;
    logic          out_fin_reg, out_fin_next;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    wr_data;

    assign dout.valid      = out_valid_reg;
    assign dout.out_bytes  = out_bytes_reg;
    assign dout.byte_count = out_cnt_reg;
    assign dout.last       = out_last_reg;
    assign dout.finished   = out_fin_reg;
    assign rd_addr         = wp_reg - AW'(off_reg);

    always_comb
    begin
        logic       can_emit;
        logic       full;
        logic       add;
        logic [7:0] b;

        can_emit = !out_valid_reg || dout.ready;
        full     = (cnt_reg == CW'(OUT_LANES));
        add      = 1'b0;
        b        = 8'h00;

        st_next        = st_reg;
        lit_next       = lit_reg;
        remain_next    = remain_reg;
        off_next       = off_reg;
        wp_next        = wp_reg;
        wrapped_next   = wrapped_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        zero_next      = zero_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_data        = 8'h00;
        out_valid_next = out_valid_reg && !dout.ready;
        out_bytes_next = out_bytes_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        out_fin_next   = out_fin_reg;

        case (st_reg)
            lbt_pkg::BK_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop         = 1'b1;
                    lit_next    = head.byte_val;
                    remain_next = head.run_len;
                    off_next    = head.offset;
                    case (head.kind)
                        lbt_pkg::CMD_LIT:  st_next = lbt_pkg::BK_LIT;
                        lbt_pkg::CMD_COPY: st_next = lbt_pkg::BK_RD;
                        lbt_pkg::CMD_END:  st_next = lbt_pkg::BK_END;
                        default:           st_next = lbt_pkg::BK_IDLE;
                    endcase
                end
            end
            lbt_pkg::BK_LIT:
            begin
                b = lit_reg;
                if (!full || can_emit)
                begin
                    add     = 1'b1;
                    st_next = lbt_pkg::BK_FLUSH;
                end
            end
            lbt_pkg::BK_RD:
            begin
                rd_en     = 1'b1;
                zero_next = (off_reg == 13'd0) || !(wrapped_reg || (rd_addr < wp_reg));
                st_next   = lbt_pkg::BK_DATA;
            end
            lbt_pkg::BK_DATA:
            begin
                b = zero_reg ? 8'h00 : rdata_reg;
                if (!full || can_emit)
                begin
                    add         = 1'b1;
                    remain_next = remain_reg - 9'd1;
                    st_next     = (remain_reg <= 9'd1) ? lbt_pkg::BK_FLUSH : lbt_pkg::BK_RD;
                end
            end
            lbt_pkg::BK_FLUSH:
            begin
                if (cnt_reg == '0)
                begin
                    st_next = lbt_pkg::BK_IDLE;
                end
                else if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_bytes_next = 64'(acc_reg);
                    out_cnt_next   = 4'(cnt_reg);
                    out_last_next  = 1'b1;
                    out_fin_next   = 1'b0;
                    acc_next       = '0;
                    cnt_next       = '0;
                    st_next        = lbt_pkg::BK_IDLE;
                end
            end
            lbt_pkg::BK_END:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_bytes_next = 64'h0;
                    out_cnt_next   = 4'd0;
                    out_last_next  = 1'b1;
                    out_fin_next   = 1'b1;
                    st_next        = lbt_pkg::BK_IDLE;
                end
            end
            default:
            begin
                st_next = lbt_pkg::BK_IDLE;
            end
        endcase

        if (add)
        begin
            wr_en   = 1'b1;
            wr_data = b;
            wp_next = wp_reg + AW'(1);
            if (wp_reg == AW'(WINDOW_DEPTH - 1))
            begin
                wrapped_next = 1'b1;
            end
            if (full)
            begin
                out_valid_next = 1'b1;
                out_bytes_next = 64'(acc_reg);
                out_cnt_next   = 4'(cnt_reg);
                out_last_next  = 1'b0;
                out_fin_next   = 1'b0;
                acc_next       = DW'(b);
                cnt_next       = CW'(1);
            end
            else
            begin
                for (int i = 0; i < OUT_LANES; i++)
                begin
                    if (CW'(i) == cnt_reg)
                    begin
                        acc_next[8*i +: 8] = b;
                    end
                end
                cnt_next = cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= lbt_pkg::BK_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg       <= lit_next;
        remain_reg    <= remain_next;
        off_reg       <= off_next;
        zero_reg      <= zero_next;
        out_bytes_reg <= out_bytes_next;
        out_cnt_reg   <= out_cnt_next;
        out_last_reg  <= out_last_next;
        out_fin_reg   <= out_fin_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule
